### sv/kcif_pkg.sv
package kcif_pkg;

    // Statement kinds.
    localparam logic [1:0] FUNC_CONST = 2'd0;
    localparam logic [1:0] FUNC_BINOP = 2'd1;

    // Binary operation kinds.
    localparam logic [3:0] OP_SUB    = 4'd0;
    localparam logic [3:0] OP_XOR    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_AND    = 4'd3;
    localparam logic [3:0] OP_OR     = 4'd4;
    localparam logic [3:0] OP_UMULHI = 4'd5;
    localparam logic [3:0] OP_SMULHI = 4'd6;
    localparam logic [3:0] OP_UDIV   = 4'd7;
    localparam logic [3:0] OP_SDIV   = 4'd8;
    localparam logic [3:0] OP_UMOD   = 4'd9;
    localparam logic [3:0] OP_SMOD   = 4'd10;

    // Operand sizes.
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;

    localparam int REF_W   = 10;
    localparam int VALUE_W = 64;
    // Table word: known flag on top of the value.
    localparam int ENTRY_W = VALUE_W + 1;

    // Queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int Q_AW   = 2;
    localparam int Q_CW   = 3;

    typedef struct packed {
        logic [1:0]         func;
        logic               has_result;
        logic [REF_W-1:0]   result_ref;
        logic [REF_W-1:0]   left_ref;
        logic [REF_W-1:0]   right_ref;
        logic [3:0]         op_kind;
        logic [1:0]         op_size;
        logic [VALUE_W-1:0] literal_value;
    } kcif_stmt_t;

    typedef struct packed {
        logic               rewritten;
        logic [VALUE_W-1:0] folded_value;
        logic [1:0]         folded_size;
    } kcif_result_t;

    typedef enum logic [1:0] {
        FOLD_NONE,
        FOLD_ZERO,
        FOLD_ONES
    } kcif_fold_t;

    typedef struct packed {
        kcif_fold_t fold;
        logic [1:0] size;
    } kcif_fold_req_t;

    function automatic logic [VALUE_W-1:0] kcif_size_mask(input logic [1:0] size);
        logic [VALUE_W-1:0] mask;
        unique case (size)
            SIZE_8:  mask = 64'h0000_0000_0000_00FF;
            SIZE_16: mask = 64'h0000_0000_0000_FFFF;
            SIZE_32: mask = 64'h0000_0000_FFFF_FFFF;
            default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

### sv/known_constant_identity_folder.sv
// Folds binary operations whose answer is a constant by algebraic identity
// (same-operand subtract or xor, absorbing zero, or with all ones, and the
// like) and learns the constants that references hold. One statement beat is
// taken per clock and every statement yields exactly one result beat, which
// passes through the lookup stage register, the queue and the output register.
// The table of known references sits in RAM and is cleared after reset by a
// pass that writes every entry, during which stmt_ready stays low. The lookup
// and table update are done in the lookup stage, with the previous update
// forwarded, and a four-entry queue lets the output register stall without
// stopping intake until the queue and the lookup stage together hold four beats.
module known_constant_identity_folder #(
    parameter int REF_COUNT = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   stmt_valid,
    output logic                   stmt_ready,
    input  kcif_pkg::kcif_stmt_t   stmt,
    output logic                   result_valid,
    input  logic                   result_ready,
    output kcif_pkg::kcif_result_t result
);
    import kcif_pkg::*;

    logic            push_valid;
    kcif_fold_req_t  push_req;
    logic            pop_valid, pop_ready;
    kcif_fold_req_t  pop_req;
    logic [Q_CW-1:0] q_count;

    kcif_front #(
        .REF_COUNT (REF_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stmt_valid (stmt_valid),
        .stmt_ready (stmt_ready),
        .stmt       (stmt),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_req   (push_req)
    );

    kcif_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req),
        .count      (q_count)
    );

    kcif_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (pop_valid),
        .req_ready    (pop_ready),
        .req          (pop_req),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### sv/kcif_ram.sv
module kcif_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old word when the same address is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/kcif_front.sv
module kcif_front #(
    parameter int REF_COUNT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      stmt_valid,
    output logic                      stmt_ready,
    input  kcif_pkg::kcif_stmt_t      stmt,
    input  logic [kcif_pkg::Q_CW-1:0] q_count,
    output logic                      push_valid,
    output kcif_pkg::kcif_fold_req_t  push_req
);
    import kcif_pkg::*;

    localparam int AW = (REF_COUNT > 1) ? $clog2(REF_COUNT) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(REF_COUNT - 1);

    logic                clr_active_reg, clr_active_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;

    logic                s1_valid_reg;
    kcif_stmt_t          s1_item_reg;
    logic                s1_lin_reg, s1_rin_reg, s1_resin_reg;

    logic                lw_valid_reg;
    logic [AW-1:0]       lw_idx_reg;
    logic [ENTRY_W-1:0]  lw_data_reg;

    logic                accept;
    logic [Q_CW:0]       credit_used;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [ENTRY_W-1:0]  l_ram, r_ram, l_entry, r_entry;

    logic [AW-1:0]       l_idx, r_idx, res_idx;
    logic                lk, rk;
    logic [VALUE_W-1:0]  lv, rv, ones;
    logic                op_zero_absorb, op_left_zero, op_right_one;
    kcif_fold_t          fold;
    logic [VALUE_W-1:0]  learn_value;

    // Every beat in flight holds a queue slot in reserve, so the lookup stage never stalls.
    assign credit_used = {1'b0, q_count} + (Q_CW+1)'(s1_valid_reg);
    assign stmt_ready  = !clr_active_reg && (credit_used < (Q_CW+1)'(QDEPTH));
    assign accept      = stmt_valid && stmt_ready;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            s1_valid_reg   <= accept;
            if (we)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= stmt;
            s1_lin_reg   <= 32'(stmt.left_ref) < REF_COUNT;
            s1_rin_reg   <= 32'(stmt.right_ref) < REF_COUNT;
            s1_resin_reg <= 32'(stmt.result_ref) < REF_COUNT;
        end
        if (we)
        begin
            lw_idx_reg  <= waddr;
            lw_data_reg <= wdata;
        end
    end

    // One table copy per operand so both lookups happen in the same cycle.
    kcif_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (REF_COUNT)
    ) u_left_tbl (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (AW'(stmt.left_ref)),
        .rdata (l_ram)
    );

    kcif_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (REF_COUNT)
    ) u_right_tbl (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (AW'(stmt.right_ref)),
        .rdata (r_ram)
    );

    assign l_idx   = AW'(s1_item_reg.left_ref);
    assign r_idx   = AW'(s1_item_reg.right_ref);
    assign res_idx = AW'(s1_item_reg.result_ref);

    // The write of the previous beat lands at the same edge as this beat's read.
    assign l_entry = (lw_valid_reg && lw_idx_reg == l_idx) ? lw_data_reg : l_ram;
    assign r_entry = (lw_valid_reg && lw_idx_reg == r_idx) ? lw_data_reg : r_ram;

    assign lk   = s1_lin_reg && l_entry[ENTRY_W-1];
    assign rk   = s1_rin_reg && r_entry[ENTRY_W-1];
    assign lv   = l_entry[VALUE_W-1:0];
    assign rv   = r_entry[VALUE_W-1:0];
    assign ones = kcif_size_mask(s1_item_reg.op_size);

    always_comb
    begin
        op_zero_absorb = (s1_item_reg.op_kind == OP_MUL) || (s1_item_reg.op_kind == OP_AND)
                      || (s1_item_reg.op_kind == OP_UMULHI)
                      || (s1_item_reg.op_kind == OP_SMULHI);
        op_right_one   = (s1_item_reg.op_kind == OP_UMULHI) || (s1_item_reg.op_kind == OP_UMOD)
                      || (s1_item_reg.op_kind == OP_SMOD);
        op_left_zero   = op_zero_absorb || (s1_item_reg.op_kind == OP_UDIV)
                      || (s1_item_reg.op_kind == OP_SDIV) || (s1_item_reg.op_kind == OP_UMOD)
                      || (s1_item_reg.op_kind == OP_SMOD);

        fold = FOLD_NONE;
        if (s1_item_reg.func == FUNC_BINOP && s1_item_reg.has_result)
        begin
            if (s1_item_reg.left_ref == s1_item_reg.right_ref
                && (s1_item_reg.op_kind == OP_SUB || s1_item_reg.op_kind == OP_XOR))
            begin
                fold = FOLD_ZERO;
            end
            else if (rk && op_zero_absorb && rv == '0)
            begin
                fold = FOLD_ZERO;
            end
            else if (rk && s1_item_reg.op_kind == OP_OR && rv == ones)
            begin
                fold = FOLD_ONES;
            end
            else if (rk && op_right_one && rv == VALUE_W'(1))
            begin
                fold = FOLD_ZERO;
            end
            else if (lk && op_left_zero && lv == '0)
            begin
                fold = FOLD_ZERO;
            end
            else if (lk && s1_item_reg.op_kind == OP_OR && lv == ones)
            begin
                fold = FOLD_ONES;
            end
        end
    end

    always_comb
    begin
        if (s1_item_reg.func == FUNC_CONST)
        begin
            learn_value = s1_item_reg.literal_value & ones;
        end
        else if (fold == FOLD_ONES)
        begin
            learn_value = ones;
        end
        else
        begin
            learn_value = '0;
        end

        if (clr_active_reg)
        begin
            we    = 1'b1;
            waddr = clr_idx_reg;
            wdata = '0;
        end
        else
        begin
            we    = s1_valid_reg && s1_item_reg.has_result && s1_resin_reg
                 && (s1_item_reg.func == FUNC_CONST || fold != FOLD_NONE);
            waddr = res_idx;
            wdata = {1'b1, learn_value};
        end
    end

    assign push_valid    = s1_valid_reg;
    assign push_req.fold = fold;
    assign push_req.size = s1_item_reg.op_size;

endmodule

### sv/kcif_queue.sv
module kcif_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push_valid,
    input  kcif_pkg::kcif_fold_req_t  push_req,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output kcif_pkg::kcif_fold_req_t  pop_req,
    output logic [kcif_pkg::Q_CW-1:0] count
);
    import kcif_pkg::*;

    kcif_fold_req_t   slots_reg [QDEPTH];
    logic [Q_AW-1:0]  wptr_reg, wptr_next;
    logic [Q_AW-1:0]  rptr_reg, rptr_next;
    logic [Q_CW-1:0]  count_reg, count_next;
    logic             pop;

    assign pop_valid = count_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_req   = slots_reg[rptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wptr_next  = push_valid ? wptr_reg + Q_AW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + Q_AW'(1) : rptr_reg;
        count_next = count_reg + Q_CW'(push_valid) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slots_reg[wptr_reg] <= push_req;
        end
    end

endmodule

### sv/kcif_back.sv
module kcif_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  kcif_pkg::kcif_fold_req_t req,
    output logic                     result_valid,
    input  logic                     result_ready,
    output kcif_pkg::kcif_result_t   result
);
    import kcif_pkg::*;

    logic         out_valid_reg;
    kcif_result_t result_reg, result_next;

    assign req_ready = !out_valid_reg || result_ready;

    always_comb
    begin
        unique case (req.fold)
            FOLD_ONES:
            begin
                result_next.rewritten    = 1'b1;
                result_next.folded_value = kcif_size_mask(req.size);
                result_next.folded_size  = req.size;
            end
            FOLD_ZERO:
            begin
                result_next.rewritten    = 1'b1;
                result_next.folded_value = '0;
                result_next.folded_size  = req.size;
            end
            default:
            begin
                result_next.rewritten    = 1'b0;
                result_next.folded_value = '0;
                result_next.folded_size  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            out_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

### verif/kcif_fold_checker.sv
`timescale 1ns / 100ps

module kcif_fold_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   stmt_valid,
    input  logic                   stmt_ready,
    input  kcif_pkg::kcif_stmt_t   stmt,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  kcif_pkg::kcif_result_t result,
    output int                     fail_count,
    output int                     outstanding
);
    import kcif_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic               const_known [TABLE_DEPTH];
    logic [VALUE_W-1:0] const_value [TABLE_DEPTH];
    kcif_result_t       pending_folds[$];
    kcif_result_t       oldest_fold;

    function automatic logic [VALUE_W-1:0] ones_of_size(input logic [1:0] size);
        logic [VALUE_W-1:0] ones;
        case (size)
            SIZE_8:  ones = 64'h0000_0000_0000_00FF;
            SIZE_16: ones = 64'h0000_0000_0000_FFFF;
            SIZE_32: ones = 64'h0000_0000_FFFF_FFFF;
            default: ones = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return ones;
    endfunction

    // Works out the result beat of one statement and updates the table of
    // references known to hold constants.
    function automatic kcif_result_t predict_fold(input kcif_stmt_t s);
        kcif_result_t       r;
        logic [VALUE_W-1:0] ones;
        logic [VALUE_W-1:0] lv;
        logic [VALUE_W-1:0] rv;
        logic [VALUE_W-1:0] val;
        logic               lk;
        logic               rk;
        logic               hit;
        logic               mulhi;
        logic               mods;
        logic               zero_kills;
        r    = '0;
        ones = ones_of_size(s.op_size);
        if (!s.has_result)
            return r;
        if (s.func == FUNC_CONST) begin
            if (s.result_ref < TABLE_DEPTH) begin
                const_known[s.result_ref] = 1'b1;
                const_value[s.result_ref] = s.literal_value & ones;
            end
        end else if (s.func == FUNC_BINOP) begin
            lk = (s.left_ref < TABLE_DEPTH) && const_known[s.left_ref];
            rk = (s.right_ref < TABLE_DEPTH) && const_known[s.right_ref];
            lv = lk ? const_value[s.left_ref] : '0;
            rv = rk ? const_value[s.right_ref] : '0;
            mulhi = (s.op_kind == OP_UMULHI) || (s.op_kind == OP_SMULHI);
            mods  = (s.op_kind == OP_UMOD) || (s.op_kind == OP_SMOD);
            zero_kills = (s.op_kind == OP_MUL) || (s.op_kind == OP_AND) || mulhi;
            hit = 1'b1;
            val = '0;
            if (s.left_ref == s.right_ref &&
                (s.op_kind == OP_SUB || s.op_kind == OP_XOR))
                val = '0;
            else if (rk && zero_kills && rv == '0)
                val = '0;
            else if (rk && s.op_kind == OP_OR && rv == ones)
                val = ones;
            else if (rk && (s.op_kind == OP_UMULHI || mods) && rv == 64'd1)
                val = '0;
            else if (lk && lv == '0 && (zero_kills || mods ||
                     s.op_kind == OP_UDIV || s.op_kind == OP_SDIV))
                val = '0;
            else if (lk && s.op_kind == OP_OR && lv == ones)
                val = ones;
            else
                hit = 1'b0;
            if (hit) begin
                if (s.result_ref < TABLE_DEPTH) begin
                    const_known[s.result_ref] = 1'b1;
                    const_value[s.result_ref] = val;
                end
                r.rewritten    = 1'b1;
                r.folded_value = val;
                r.folded_size  = s.op_size;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                const_known[i] = 1'b0;
            pending_folds.delete();
            fail_count  = 0;
            outstanding = 0;
        end else begin
            // The result side is handled first: a result beat can never
            // belong to a statement taken at the same edge.
            if (result_valid && result_ready) begin
                if (pending_folds.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result beat rewritten=%0b value=%h size=%0d",
                                 $realtime, result.rewritten, result.folded_value,
                                 result.folded_size);
                end else begin
                    oldest_fold = pending_folds.pop_front();
                    if (result.rewritten !== oldest_fold.rewritten ||
                        result.folded_value !== oldest_fold.folded_value ||
                        result.folded_size !== oldest_fold.folded_size) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected %0b/%h/%0d, got %0b/%h/%0d",
                                     $realtime, oldest_fold.rewritten,
                                     oldest_fold.folded_value, oldest_fold.folded_size,
                                     result.rewritten, result.folded_value,
                                     result.folded_size);
                    end
                end
            end
            if (stmt_valid && stmt_ready)
                pending_folds.insert(pending_folds.size(), predict_fold(stmt));
            outstanding = pending_folds.size();
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

    import kcif_pkg::*;

    localparam int          REF_COUNT   = 1024;
    localparam int          PHASE_ITEMS = 333;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 20;
    localparam logic [1:0]  SIZE_64     = 2'd3;
    localparam logic [1:0]  FUNC_OTHER  = 2'd2;
    localparam logic [1:0]  FUNC_SPARE  = 2'd3;
    localparam logic [3:0]  OP_OTHER    = 4'd11;
    localparam logic [3:0]  OP_TOP      = 4'd15;
    localparam logic [63:0] LIT_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         stmt_valid   = 1'b0;
    logic         stmt_ready;
    kcif_stmt_t   stmt         = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    kcif_result_t result;
    int           fail_count;
    int           outstanding;
    int           send_idle_pct = 29;
    int           recv_idle_pct = 54;
    int           cycle_count   = 0;

    known_constant_identity_folder #(
        .REF_COUNT(REF_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .stmt_valid  (stmt_valid),
        .stmt_ready  (stmt_ready),
        .stmt        (stmt),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    kcif_fold_checker #(
        .TABLE_DEPTH(REF_COUNT)
    ) fold_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .stmt_valid  (stmt_valid),
        .stmt_ready  (stmt_ready),
        .stmt        (stmt),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic kcif_stmt_t make_stmt(input logic [1:0] func, input logic has_result,
                                             input int rref, input int lref, input int rgt,
                                             input logic [3:0] op, input logic [1:0] size,
                                             input logic [63:0] lit);
        kcif_stmt_t s;
        s.func          = func;
        s.has_result    = has_result;
        s.result_ref    = rref[REF_W-1:0];
        s.left_ref      = lref[REF_W-1:0];
        s.right_ref     = rgt[REF_W-1:0];
        s.op_kind       = op;
        s.op_size       = size;
        s.literal_value = lit;
        return s;
    endfunction

    // Most references come from a small pool so that constants get learned
    // and identities fire; a few reach across the whole table.
    function automatic int pick_ref();
        int r;
        if ($urandom_range(9) == 0)
            r = $urandom_range(REF_COUNT - 1);
        else
            r = $urandom_range(15);
        return r;
    endfunction

    function automatic kcif_stmt_t random_stmt();
        kcif_stmt_t s;
        int         pick;
        int         lit_pick;
        pick = $urandom_range(99);
        s.func          = 2'($urandom_range(3));
        s.has_result    = 1'($urandom_range(1));
        s.result_ref    = REF_W'($urandom_range(REF_COUNT - 1));
        s.left_ref      = REF_W'($urandom_range(REF_COUNT - 1));
        s.right_ref     = REF_W'($urandom_range(REF_COUNT - 1));
        s.op_kind       = 4'($urandom_range(15));
        s.op_size       = 2'($urandom_range(3));
        s.literal_value = {$urandom, $urandom};
        if (pick < 30) begin
            s.func       = FUNC_CONST;
            s.has_result = ($urandom_range(9) != 0);
            s.result_ref = REF_W'(pick_ref());
            lit_pick     = $urandom_range(3);
            if (lit_pick == 0)
                s.literal_value = '0;
            else if (lit_pick == 1)
                s.literal_value = 64'd1;
            else if (lit_pick == 2)
                s.literal_value = LIT_MAX;
        end else if (pick < 85) begin
            s.func       = FUNC_BINOP;
            s.has_result = ($urandom_range(9) != 0);
            s.result_ref = REF_W'(pick_ref());
            s.left_ref   = REF_W'(pick_ref());
            s.right_ref  = ($urandom_range(4) == 0) ? s.left_ref : REF_W'(pick_ref());
            s.op_kind    = ($urandom_range(9) == 0) ? 4'($urandom_range(OP_TOP))
                                                    : 4'($urandom_range(OP_SMOD));
        end
        return s;
    endfunction

    task automatic send_stmt(input kcif_stmt_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            stmt_valid <= 1'b0;
            @(posedge clk);
        end
        stmt_valid <= 1'b1;
        stmt       <= s;
        do
            @(posedge clk);
        while (!stmt_ready);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Constants, with masking to the operand size.
        send_stmt(make_stmt(FUNC_CONST, 1'b1, 1, 0, 0, OP_SUB, SIZE_64, '0));
        send_stmt(make_stmt(FUNC_CONST, 1'b1, 2, 0, 0, OP_SUB, SIZE_8, 64'd1));
        send_stmt(make_stmt(FUNC_CONST, 1'b1, 3, 0, 0, OP_SUB, SIZE_8, LIT_MAX));
        send_stmt(make_stmt(FUNC_CONST, 1'b1, 4, 0, 0, OP_SUB, SIZE_64, LIT_MAX));
        // Same operand subtract and xor.
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 10, 5, 5, OP_SUB, SIZE_64, LIT_MAX));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 11, 6, 6, OP_XOR, SIZE_16, '0));
        // Zero and all-ones operands on either side.
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 12, 7, 1, OP_MUL, SIZE_64, '0));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 13, 1, 7, OP_AND, SIZE_32, '0));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 14, 7, 3, OP_OR, SIZE_8, '0));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 15, 4, 7, OP_OR, SIZE_64, '0));
        // Operand of one: only unsigned high multiply and modulo fold; a zero dividend folds too.
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 16, 7, 2, OP_UMULHI, SIZE_32, '0));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 17, 7, 2, OP_SMULHI, SIZE_16, '0));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 18, 7, 2, OP_UMOD, SIZE_8, '0));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 19, 7, 2, OP_SMOD, SIZE_64, '0));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 20, 1, 7, OP_UDIV, SIZE_64, '0));
        // Both operands known.
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 21, 1, 2, OP_SDIV, SIZE_8, '0));
        // Divide by one is a copy and must not fold.
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 22, 7, 2, OP_UDIV, SIZE_8, '0));
        // Ignored statements.
        send_stmt(make_stmt(FUNC_BINOP, 1'b0, 23, 5, 5, OP_SUB, SIZE_64, '0));
        send_stmt(make_stmt(FUNC_OTHER, 1'b1, 24, 5, 5, OP_SUB, SIZE_64, '0));
        send_stmt(make_stmt(FUNC_SPARE, 1'b1, 25, 5, 5, OP_XOR, SIZE_64, LIT_MAX));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 26, 1, 1, OP_OTHER, SIZE_32, '0));
        // All ones of a wider size is not all ones of a narrower one.
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 27, 7, 4, OP_OR, SIZE_8, '0));
        // A folded result feeds a later fold; top of the table.
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 28, 7, 12, OP_UMULHI, SIZE_64, '0));
        send_stmt(make_stmt(FUNC_CONST, 1'b1, 1023, 0, 0, OP_SUB, SIZE_16, 64'h1_0000));
        send_stmt(make_stmt(FUNC_BINOP, 1'b1, 1022, 1023, 1023, OP_AND, SIZE_16, '0));

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct <= 54;
                recv_idle_pct <= 29;
            end else if (phase == 2) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            repeat (PHASE_ITEMS) send_stmt(random_stmt());
        end
        stmt_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
